[sv/natwl_pkg.sv]
package natwl_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [1:0] KIND_EXACT    = 2'd0;
    localparam logic [1:0] KIND_IPSTAR   = 2'd1;
    localparam logic [1:0] KIND_STARPORT = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_WILD = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] xlat_addr;
        logic [15:0] xlat_port;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[sv/nat_wildcard_lookup_table_core.sv]
// NAT rule table with wildcard keys (exact ip:port, ip:*, *:port).
// Input channel s_*: one request per transfer, s_req_type selects insert
// or lookup. Result channel m_*: exactly one result transfer per request.
// Every request walks all ENTRIES rule slots through the single registered
// read port of the rule RAM, one slot per cycle, then a decide/write state.
// m_valid rises in the same cycle that s_ready returns, so the block takes
// no new request until the result of the current one is loaded. An insert
// with both parts wildcarded skips the walk and goes straight to the
// decide/write state.
// Lookups try exact, then ip:*, then *:port and return the translation.
// Inserts overwrite a rule with the same key or take the lowest free slot.
// The result sits in an output register; s_ready returns as soon as the
// result is loaded, so the next request can start while it waits. If the
// receiver stalls, the next request completes its walk and then holds in
// the decide/write state until the pending result is taken.
// Reset (aresetn low, synchronous) clears all slot valid bits and both
// channels' control state; the table is empty afterwards.
module nat_wildcard_lookup_table_core
    import natwl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [31:0] s_key_ip,
    input  logic [15:0] s_key_port,
    input  logic        s_ip_wild,
    input  logic        s_port_wild,
    input  logic [31:0] s_new_ip,
    input  logic [15:0] s_new_port,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [31:0] m_out_ip,
    output logic [15:0] m_out_port,
    output logic [1:0]  m_status
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]         state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic               m_valid_reg;

    logic        req_reg;
    logic [31:0] kip_reg;
    logic [15:0] kport_reg;
    logic        iw_reg;
    logic        pw_reg;
    logic [31:0] nip_reg;
    logic [15:0] nport_reg;

    logic [2:0]       slot_hit_reg;
    logic [IDX_W-1:0] slot_idx_reg [3];
    logic [31:0]      slot_xa_reg [3];
    logic [15:0]      slot_xp_reg [3];
    logic             free_hit_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic        hit_reg;
    logic [31:0] out_ip_reg;
    logic [15:0] out_port_reg;
    logic [1:0]  status_reg;

    logic             rd_en;
    entry_t           rd_ent;
    logic             ent_valid;
    logic [2:0]       slot_match;
    logic [1:0]       ins_kind;
    logic [31:0]      ins_addr;
    logic [15:0]      ins_port;
    logic             ins_match;
    logic             fin_go;
    logic             wr_req;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_ent;
    logic             res_hit;
    logic [31:0]      res_ip;
    logic [15:0]      res_port;
    logic [1:0]       res_status;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_hit      = hit_reg;
    assign m_out_ip   = out_ip_reg;
    assign m_out_port = out_port_reg;
    assign m_status   = status_reg;

    assign rd_en     = (state_reg == ST_SCAN) && (cnt_reg < CNT_W'(ENTRIES));
    assign ent_valid = rd_vld_reg && valid_reg[rd_idx_reg];
    assign fin_go    = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    always_comb begin
        priority if (iw_reg) begin
            ins_kind = KIND_STARPORT;
        end else if (pw_reg) begin
            ins_kind = KIND_IPSTAR;
        end else begin
            ins_kind = KIND_EXACT;
        end
        ins_addr = iw_reg ? 32'd0 : kip_reg;
        ins_port = pw_reg ? 16'd0 : kport_reg;
    end

    always_comb begin
        unique case (ins_kind)
            KIND_EXACT:    ins_match = (rd_ent.addr == ins_addr) && (rd_ent.port == ins_port);
            KIND_IPSTAR:   ins_match = (rd_ent.addr == ins_addr);
            KIND_STARPORT: ins_match = (rd_ent.port == ins_port);
            default:       ins_match = 1'b0;
        endcase
        if (req_reg == REQ_LOOKUP) begin
            slot_match[0] = (rd_ent.kind == KIND_EXACT) && (rd_ent.addr == kip_reg)
                            && (rd_ent.port == kport_reg);
            slot_match[1] = (rd_ent.kind == KIND_IPSTAR) && (rd_ent.addr == kip_reg);
            slot_match[2] = (rd_ent.kind == KIND_STARPORT) && (rd_ent.port == kport_reg);
        end else begin
            slot_match[0] = (rd_ent.kind == ins_kind) && ins_match;
            slot_match[1] = 1'b0;
            slot_match[2] = 1'b0;
        end
        slot_match = slot_match & {3{ent_valid}};
    end

    always_comb begin
        wr_req     = 1'b0;
        wr_idx     = slot_idx_reg[0];
        res_hit    = 1'b0;
        res_ip     = 32'd0;
        res_port   = 16'd0;
        res_status = STATUS_OK;
        if (req_reg == REQ_LOOKUP) begin
            priority if (slot_hit_reg[0]) begin
                res_hit  = 1'b1;
                res_ip   = slot_xa_reg[0];
                res_port = slot_xp_reg[0];
            end else if (slot_hit_reg[1]) begin
                res_hit  = 1'b1;
                res_ip   = slot_xa_reg[1];
                res_port = slot_xp_reg[1];
            end else if (slot_hit_reg[2]) begin
                res_hit  = 1'b1;
                res_ip   = slot_xa_reg[2];
                res_port = slot_xp_reg[2];
            end
        end else begin
            priority if (iw_reg && pw_reg) begin
                res_status = STATUS_WILD;
            end else if (slot_hit_reg[0]) begin
                wr_req = 1'b1;
            end else if (free_hit_reg) begin
                wr_req = 1'b1;
                wr_idx = free_idx_reg;
            end else begin
                res_status = STATUS_FULL;
            end
        end
        wr_ent.kind      = ins_kind;
        wr_ent.addr      = ins_addr;
        wr_ent.port      = ins_port;
        wr_ent.xlat_addr = nip_reg;
        wr_ent.xlat_port = nport_reg;
    end

    natwl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ENTRIES)
    ) u_rule_ram (
        .clk    (aclk),
        .wr_en  (fin_go && wr_req),
        .wr_addr(wr_idx),
        .wr_data(wr_ent),
        .rd_en  (rd_en),
        .rd_addr(cnt_reg[IDX_W-1:0]),
        .rd_data(rd_ent)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
            slot_hit_reg <= '0;
            free_hit_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
            if (fin_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (rd_vld_reg) begin
                slot_hit_reg <= slot_hit_reg | slot_match;
                if (!free_hit_reg && !valid_reg[rd_idx_reg]) begin
                    free_hit_reg <= 1'b1;
                end
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cnt_reg      <= '0;
                        slot_hit_reg <= '0;
                        free_hit_reg <= 1'b0;
                        if ((s_req_type == REQ_INSERT) && s_ip_wild && s_port_wild) begin
                            state_reg <= ST_FINISH;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ENTRIES)) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (fin_go) begin
                        state_reg <= ST_IDLE;
                        if (wr_req) begin
                            valid_reg[wr_idx] <= 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg[IDX_W-1:0];
        if (s_valid && s_ready) begin
            req_reg   <= s_req_type;
            kip_reg   <= s_key_ip;
            kport_reg <= s_key_port;
            iw_reg    <= s_ip_wild;
            pw_reg    <= s_port_wild;
            nip_reg   <= s_new_ip;
            nport_reg <= s_new_port;
        end
        if (rd_vld_reg) begin
            for (int k = 0; k < 3; k++) begin
                if (!slot_hit_reg[k] && slot_match[k]) begin
                    slot_idx_reg[k] <= rd_idx_reg;
                    slot_xa_reg[k]  <= rd_ent.xlat_addr;
                    slot_xp_reg[k]  <= rd_ent.xlat_port;
                end
            end
            if (!free_hit_reg && !valid_reg[rd_idx_reg]) begin
                free_idx_reg <= rd_idx_reg;
            end
        end
        if (fin_go) begin
            hit_reg      <= res_hit;
            out_ip_reg   <= res_ip;
            out_port_reg <= res_port;
            status_reg   <= res_status;
        end
    end

endmodule

[sv/natwl_ram.sv]
module natwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[test/nat_wildcard_lookup_table_core_tb.sv]
`timescale 1ns / 1ps

module nat_wildcard_lookup_table_core_tb
    import natwl_pkg::*;
();

    localparam int RANDOM_REQS = 2000;
    localparam int QUIET_TAIL  = 250;
    localparam int POOL_SIZE   = 12;
    localparam int POOL_IDX_W  = $clog2(POOL_SIZE);
    localparam int DRAIN_WAIT  = 2 * (ENTRIES + 3);
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic        hit;
        logic [31:0] ip;
        logic [15:0] port;
        logic [1:0]  status;
    } xlat_result_t;

    class nat_scoreboard;
        bit          rule_valid [ENTRIES];
        logic [1:0]  rule_kind  [ENTRIES];
        logic [31:0] rule_addr  [ENTRIES];
        logic [15:0] rule_port  [ENTRIES];
        logic [31:0] rule_xaddr [ENTRIES];
        logic [15:0] rule_xport [ENTRIES];
        xlat_result_t pending_results[$];
        int errors, n_insert, n_lookup, n_hit, n_full, n_wild, n_overwrite;

        function int find_rule(logic [1:0] kind, logic [31:0] addr, logic [15:0] port);
            for (int i = 0; i < ENTRIES; i++) begin
                if (rule_valid[i] && rule_kind[i] == kind && rule_addr[i] == addr &&
                    rule_port[i] == port)
                    return i;
            end
            return -1;
        endfunction

        function void note_request(logic req, logic [31:0] kip, logic [15:0] kport,
                                   logic iw, logic pw, logic [31:0] nip,
                                   logic [15:0] nport);
            xlat_result_t res;
            logic [1:0]   kind;
            logic [31:0]  addr;
            logic [15:0]  port;
            int           idx;
            res = '0;
            res.status = STATUS_OK;
            if (req == REQ_INSERT) begin
                n_insert++;
                if (iw && pw) begin
                    res.status = STATUS_WILD;
                    n_wild++;
                end else begin
                    if (iw) begin
                        kind = KIND_STARPORT; addr = '0; port = kport;
                    end else if (pw) begin
                        kind = KIND_IPSTAR; addr = kip; port = '0;
                    end else begin
                        kind = KIND_EXACT; addr = kip; port = kport;
                    end
                    idx = find_rule(kind, addr, port);
                    if (idx >= 0)
                        n_overwrite++;
                    for (int i = 0; i < ENTRIES && idx < 0; i++) begin
                        if (!rule_valid[i])
                            idx = i;
                    end
                    if (idx < 0) begin
                        res.status = STATUS_FULL;
                        n_full++;
                    end else begin
                        rule_valid[idx] = 1'b1;
                        rule_kind[idx]  = kind;
                        rule_addr[idx]  = addr;
                        rule_port[idx]  = port;
                        rule_xaddr[idx] = nip;
                        rule_xport[idx] = nport;
                    end
                end
            end else begin
                n_lookup++;
                idx = find_rule(KIND_EXACT, kip, kport);
                if (idx < 0)
                    idx = find_rule(KIND_IPSTAR, kip, '0);
                if (idx < 0)
                    idx = find_rule(KIND_STARPORT, '0, kport);
                if (idx >= 0) begin
                    res.hit  = 1'b1;
                    res.ip   = rule_xaddr[idx];
                    res.port = rule_xport[idx];
                    n_hit++;
                end
            end
            pending_results.insert(pending_results.size(), res);
        endfunction

        function void check_result(logic hit, logic [31:0] ip, logic [15:0] port,
                                   logic [1:0] status);
            xlat_result_t exp_res;
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected: %s=%0b %s=%h %s=%h %s=%0d",
                         $time, "hit", hit, "ip", ip, "port", port, "status", status);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (hit !== exp_res.hit) begin
                $display("%0t: hit mismatch: expected %0b, actual %0b", $time, exp_res.hit, hit);
                errors++;
            end
            if (ip !== exp_res.ip) begin
                $display("%0t: out_ip mismatch: expected %h, actual %h", $time, exp_res.ip, ip);
                errors++;
            end
            if (port !== exp_res.port) begin
                $display("%0t: out_port mismatch: expected %h, actual %h",
                         $time, exp_res.port, port);
                errors++;
            end
            if (status !== exp_res.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, exp_res.status, status);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_req_type;
    logic [31:0] s_key_ip;
    logic [15:0] s_key_port;
    logic        s_ip_wild;
    logic        s_port_wild;
    logic [31:0] s_new_ip;
    logic [15:0] s_new_port;
    logic        m_valid;
    logic        m_ready;
    logic        m_hit;
    logic [31:0] m_out_ip;
    logic [15:0] m_out_port;
    logic [1:0]  m_status;

    nat_scoreboard sb = new();
    bit            idle_en;
    logic [31:0]   ip_pool   [POOL_SIZE];
    logic [15:0]   port_pool [POOL_SIZE];

    nat_wildcard_lookup_table_core u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_key_ip   (s_key_ip),
        .s_key_port (s_key_port),
        .s_ip_wild  (s_ip_wild),
        .s_port_wild(s_port_wild),
        .s_new_ip   (s_new_ip),
        .s_new_port (s_new_port),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hit      (m_hit),
        .m_out_ip   (m_out_ip),
        .m_out_port (m_out_port),
        .m_status   (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, sb.pending_results.size());
        $display("nat_wildcard_lookup_table_core_tb failed");
        $finish;
    end

    // result side: check each transfer, stall in random bursts
    initial begin
        int unsigned hold;
        hold = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_hit, m_out_ip, m_out_port, m_status);
            if (hold > 0) begin
                hold--;
                m_ready <= (hold == 0);
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic req, input logic [31:0] kip,
                                input logic [15:0] kport, input logic iw, input logic pw,
                                input logic [31:0] nip, input logic [15:0] nport);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_key_ip    <= kip;
        s_key_port  <= kport;
        s_ip_wild   <= iw;
        s_port_wild <= pw;
        s_new_ip    <= nip;
        s_new_port  <= nport;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req, kip, kport, iw, pw, nip, nport);
    endtask

    // mostly pool keys so rules collide, overwrite and hit; some raw noise
    task automatic send_random();
        int unsigned pick, sel;
        logic        iw, pw;
        logic [31:0] kip;
        logic [15:0] kport;
        pick  = $urandom_range(0, 99);
        kip   = ip_pool[POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1))];
        kport = port_pool[POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1))];
        if (pick < 10) begin
            send_request(1'($urandom), $urandom, 16'($urandom), 1'($urandom),
                         1'($urandom), $urandom, 16'($urandom));
        end else if (pick < 45) begin
            sel = $urandom_range(0, 2);
            iw  = (sel == 2);
            pw  = (sel == 1);
            if (iw)
                kip = $urandom;
            if (pw)
                kport = 16'($urandom);
            send_request(REQ_INSERT, kip, kport, iw, pw, $urandom, 16'($urandom));
        end else if (pick < 50) begin
            send_request(REQ_INSERT, $urandom, 16'($urandom), 1'b1, 1'b1, $urandom,
                         16'($urandom));
        end else begin
            if ($urandom_range(0, 9) == 0)
                kip = $urandom;
            if ($urandom_range(0, 9) == 0)
                kport = 16'($urandom);
            send_request(REQ_LOOKUP, kip, kport, 1'($urandom), 1'($urandom), $urandom,
                         16'($urandom));
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        idle_en     <= 1'b1;
        s_valid     <= 1'b0;
        s_req_type  <= REQ_INSERT;
        s_key_ip    <= '0;
        s_key_port  <= '0;
        s_ip_wild   <= 1'b0;
        s_port_wild <= 1'b0;
        s_new_ip    <= '0;
        s_new_port  <= '0;
        ip_pool[0]   = 32'h0000_0000;
        ip_pool[1]   = 32'hFFFF_FFFF;
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++) begin
            ip_pool[i]   = $urandom;
            port_pool[i] = 16'($urandom);
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes of every field
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(REQ_INSERT, 32'h0, 16'h0, 1'b0, 1'b0, 32'h0, 16'h0);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0, 32'h0, 16'h0);
        send_request(REQ_LOOKUP, 32'h0, 16'h0, 1'b0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF);
        // wildcard priority: exact, then ip:*, then *:port
        send_request(REQ_INSERT, 32'h0A00_0001, 16'hFFFF, 1'b0, 1'b1, 32'hC0A8_0001, 16'h1000);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 16'd80, 1'b1, 1'b0, 32'hC0A8_0002, 16'h2000);
        send_request(REQ_LOOKUP, 32'h0A00_0001, 16'd80, 1'b0, 1'b0, 32'h0, 16'h0);
        send_request(REQ_INSERT, 32'h0A00_0001, 16'd80, 1'b0, 1'b0, 32'hC0A8_0003, 16'h3000);
        send_request(REQ_LOOKUP, 32'h0A00_0001, 16'd80, 1'b0, 1'b0, 32'h0, 16'h0);
        send_request(REQ_LOOKUP, 32'h0A00_0002, 16'd80, 1'b0, 1'b0, 32'h0, 16'h0);
        send_request(REQ_LOOKUP, 32'h0A00_0001, 16'd443, 1'b0, 1'b0, 32'h0, 16'h0);
        // miss
        send_request(REQ_LOOKUP, 32'h0102_0304, 16'd5, 1'b0, 1'b0, 32'h0, 16'h0);
        // both parts wildcarded
        send_request(REQ_INSERT, 32'h0A00_0009, 16'd99, 1'b1, 1'b1, 32'h1234_5678, 16'h9ABC);
        send_request(REQ_LOOKUP, 32'h0A00_0009, 16'd99, 1'b0, 1'b0, 32'h0, 16'h0);
        // lookup ignores wildcard flags and translation fields
        send_request(REQ_LOOKUP, 32'h0A00_0003, 16'd80, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        // overwrite of an existing key
        send_request(REQ_INSERT, 32'h0A00_0001, 16'd80, 1'b0, 1'b0, 32'hDEAD_BEEF, 16'hBEEF);
        send_request(REQ_LOOKUP, 32'h0A00_0001, 16'd80, 1'b0, 1'b0, 32'h0, 16'h0);
        // port 0 and address octet 0 stay separate keys
        send_request(REQ_INSERT, 32'h0500_0000, 16'h0, 1'b1, 1'b0, 32'h1111_1111, 16'h1111);
        send_request(REQ_INSERT, 32'h0, 16'h0005, 1'b0, 1'b1, 32'h2222_2222, 16'h2222);
        send_request(REQ_LOOKUP, 32'h0500_0000, 16'h0, 1'b0, 1'b0, 32'h0, 16'h0);
        send_request(REQ_LOOKUP, 32'h0, 16'h0007, 1'b0, 1'b0, 32'h0, 16'h0);
        send_request(REQ_LOOKUP, 32'h0, 16'h0, 1'b0, 1'b0, 32'h0, 16'h0);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            idle_en <= !(n >= RANDOM_REQS - QUIET_TAIL || (n >= 900 && n < 1100));
            send_random();
        end
        s_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d inserts (%0d overwrites, %0d table full, %0d both wildcard)",
                 sb.n_insert, sb.n_overwrite, sb.n_full, sb.n_wild);
        $display("and %0d lookups with %0d hits, %0d field mismatches",
                 sb.n_lookup, sb.n_hit, sb.errors);
        if (sb.errors == 0)
            $display("nat_wildcard_lookup_table_core_tb passed");
        else
            $display("nat_wildcard_lookup_table_core_tb failed");
        $finish;
    end

endmodule
